// ===== hw/rtl/mls_pkg.sv =====
package mls_pkg;

   // default sizing of the threshold store and the size datapath
   localparam int MAX_LODS_DEF   = 8;
   localparam int MESH_COUNT_DEF = 256;
   localparam int SIZE_BITS_DEF  = 16;

   // fixed field widths
   localparam int MESH_W   = 8;
   localparam int LVL_W    = 3;
   localparam int THR_W    = 16;
   localparam int SCALE_W  = 16;
   localparam int HYST_W   = 8;
   localparam int BIAS_W   = 5;
   localparam int NLOD_W   = 4;
   localparam int FRAC_W   = 12;
   localparam int REQ_DW   = 64;
   localparam int RSP_DW   = 8;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 16;

   // request kinds carried on tuser
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SELECT = 1'b1;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_FORCE_LOD   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_SIZE_SCALE  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_HYSTERESIS  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_GLOBAL_BIAS = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MIN_LOD     = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_MAX_LOD     = 3'd5;

   // register reset values
   localparam logic [3:0]        RST_FORCE_LOD   = 4'hF;
   localparam logic [SCALE_W-1:0] RST_SIZE_SCALE = 16'd4096;
   localparam logic [HYST_W-1:0] RST_HYSTERESIS  = 8'd26;
   localparam logic [BIAS_W-1:0] RST_GLOBAL_BIAS = 5'd0;
   localparam logic [LVL_W-1:0]  RST_MIN_LOD     = 3'd0;
   localparam logic [3:0]        RST_MAX_LOD     = 4'hF;

   // hysteresis saturates at one half
   localparam logic [HYST_W-1:0] HYST_MAX = 8'd128;

   typedef struct packed {
      logic signed [3:0]        force_lod;
      logic [SCALE_W-1:0]       size_scale;
      logic [HYST_W-1:0]        hysteresis;
      logic signed [BIAS_W-1:0] global_bias;
      logic [LVL_W-1:0]         min_lod;
      logic signed [3:0]        max_lod;
   } cfg_type;

endpackage

// ===== hw/rtl/mls_cfg_regs.sv =====
module mls_cfg_regs (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [mls_pkg::CSR_AW-1:0] csr_addr,
   input  logic [mls_pkg::CSR_DW-1:0] csr_wdata,
   output mls_pkg::cfg_type           cfg
);

   mls_pkg::cfg_type cfg_ff;
   mls_pkg::cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            mls_pkg::CSR_FORCE_LOD:   cfg_in.force_lod   = csr_wdata[3:0];
            mls_pkg::CSR_SIZE_SCALE:  cfg_in.size_scale  = csr_wdata[15:0];
            mls_pkg::CSR_HYSTERESIS:  cfg_in.hysteresis  = csr_wdata[7:0];
            mls_pkg::CSR_GLOBAL_BIAS: cfg_in.global_bias = csr_wdata[4:0];
            mls_pkg::CSR_MIN_LOD:     cfg_in.min_lod     = csr_wdata[2:0];
            mls_pkg::CSR_MAX_LOD:     cfg_in.max_lod     = csr_wdata[3:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.force_lod   <= mls_pkg::RST_FORCE_LOD;
         cfg_ff.size_scale  <= mls_pkg::RST_SIZE_SCALE;
         cfg_ff.hysteresis  <= mls_pkg::RST_HYSTERESIS;
         cfg_ff.global_bias <= mls_pkg::RST_GLOBAL_BIAS;
         cfg_ff.min_lod     <= mls_pkg::RST_MIN_LOD;
         cfg_ff.max_lod     <= mls_pkg::RST_MAX_LOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/mls_thresh_mem.sv =====
module mls_thresh_mem #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mesh_lod_selector.sv =====
// Mesh level-of-detail selector.
// Input channel req_*: tuser is the request kind. A write stores one authored
// screen-size threshold for (mesh_index, lod_index) and gives no result. A
// select returns one level on the result channel rsp_*.
// Registers on csr_* are registered and must only change while idle.
// A write is stored in the table as it is accepted. A forced select (global
// or per-mesh force) goes straight to the done state and from there into the
// output register. An automatic select on a mesh with n levels reads
// thresholds 1..n-1 from the table, one per cycle through the single read
// port; each passes the running minimum and a compare before ST_DONE.
// One request is worked on at a time; req_tready is high whenever no select
// is in progress, so writes pass at one per cycle.
// The result sits in an output register; while the receiver holds rsp_tready
// low the finished level waits there, and a following select completes its
// scan but holds until the register is free.
// Reset clears control state and restores register defaults, not the table:
// the user must write an entry before it is read; the block does not check.
module mesh_lod_selector #(
   parameter int MAX_LODS   = mls_pkg::MAX_LODS_DEF,
   parameter int MESH_COUNT = mls_pkg::MESH_COUNT_DEF,
   parameter int SIZE_BITS  = mls_pkg::SIZE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // mesh_index, lod_index, threshold_value, screen_size, previous_lod,
   // num_lods, forced_lod, lod_bias, view_bias
   input  logic [mls_pkg::REQ_DW-1:0] req_tdata,
   // req_type
   input  logic [0:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // selected_lod, zero fill above
   output logic [mls_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                       csr_we,
   input  logic [mls_pkg::CSR_AW-1:0] csr_addr,
   input  logic [mls_pkg::CSR_DW-1:0] csr_wdata
);

   localparam int DEPTH = MESH_COUNT * MAX_LODS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = (MESH_COUNT > 1) ? $clog2(MESH_COUNT) : 1;
   localparam int LVW   = $clog2(MAX_LODS);
   localparam int LW    = SIZE_BITS + 8;
   localparam int CW    = (SIZE_BITS + 8 > 25) ? SIZE_BITS + 8 : 25;
   localparam logic [32:0] SIZE_MAX = (33'd1 << SIZE_BITS) - 33'd1;
   localparam logic [7:0]  MAX_LODS8 = 8'(MAX_LODS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // request fields
   logic [7:0]         f_mesh;
   logic [2:0]         f_lvl;
   logic [15:0]        f_thr;
   logic [15:0]        f_size;
   logic [2:0]         f_prev;
   logic [3:0]         f_nlods;
   logic [3:0]         f_forced;
   logic signed [4:0]  f_lbias;
   logic signed [4:0]  f_vbias;

   assign f_mesh   = req_tdata[7:0];
   assign f_lvl    = req_tdata[10:8];
   assign f_thr    = req_tdata[26:11];
   assign f_size   = req_tdata[42:27];
   assign f_prev   = req_tdata[45:43];
   assign f_nlods  = req_tdata[49:46];
   assign f_forced = req_tdata[53:50];
   assign f_lbias  = req_tdata[58:54];
   assign f_vbias  = req_tdata[63:59];

   mls_pkg::cfg_type cfg;

   mls_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // mesh index wrap as a constant table
   logic [RW-1:0] row_lut [256];
   for (genvar g = 0; g < 256; g++) begin : g_row
      assign row_lut[g] = RW'(g % MESH_COUNT);
   end

   // control registers
   logic [1:0]          state_ff, state_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [2:0]          rsp_lod_ff, rsp_lod_in;

   // per-select context
   logic [RW-1:0]       row_ff, row_in;
   logic [2:0]          prev_ff, prev_in;
   logic [LVW-1:0]      coarse_ff, coarse_in;
   logic                forced_ff, forced_in;
   logic [7:0]          fval_ff, fval_in;
   logic signed [4:0]   lbias_ff, lbias_in;
   logic signed [4:0]   vbias_ff, vbias_in;
   logic [31:0]         prod_ff, prod_in;

   // scan pipeline
   logic                iss_act_ff, iss_act_in;
   logic [LVW-1:0]      iss_lvl_ff, iss_lvl_in;
   logic                t1_vld_ff, t1_vld_in;
   logic                t1_last_ff, t1_last_in;
   logic [LVW-1:0]      t1_lvl_ff, t1_lvl_in;
   logic [15:0]         run_ff, run_in;
   logic                s2_vld_ff, s2_vld_in;
   logic                s2_nz_ff, s2_nz_in;
   logic                s2_last_ff, s2_last_in;
   logic [LVW-1:0]      s2_lvl_ff, s2_lvl_in;
   logic [24:0]         s2_rhs_ff, s2_rhs_in;
   logic [LVW-1:0]      pick_ff, pick_in;

   // datapath nets
   logic                acc;
   logic                acc_sel;
   logic [7:0]          nl8;
   logic [7:0]          coarse8;
   logic [7:0]          force8;
   logic [15:0]         scale_eff;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [15:0]         rd_q;
   logic                nz;
   logic [15:0]         tmin;
   logic [7:0]          h_eff;
   logic [8:0]          factor;
   logic [31:0]         shifted;
   logic [SIZE_BITS-1:0] size_v;
   logic [LW-1:0]       lhs;
   logic                hit;
   logic signed [7:0]   target;
   logic signed [7:0]   lo_s;
   logic signed [7:0]   hi_s;
   logic signed [7:0]   cur_coarse;
   logic signed [7:0]   minl;
   logic signed [7:0]   maxl;
   logic signed [7:0]   res_s;
   logic                out_free;

   assign acc        = req_tvalid && req_tready;
   assign acc_sel    = acc && (req_tuser[0] == mls_pkg::REQ_SELECT);
   assign req_tready = (state_ff == ST_IDLE);

   // level count clamp and forced level at intake
   always_comb begin
      nl8 = {4'd0, f_nlods};
      if (nl8 == 8'd0) begin
         nl8 = 8'd1;
      end else if (nl8 > MAX_LODS8) begin
         nl8 = MAX_LODS8;
      end
      coarse8 = nl8 - 8'd1;
      if (!cfg.force_lod[3]) begin
         force8 = {4'd0, cfg.force_lod};
      end else begin
         force8 = {4'd0, f_forced} - 8'd1;
      end
      if (force8 > coarse8) begin
         force8 = coarse8;
      end
      scale_eff = (cfg.size_scale == 16'd0) ? 16'd1 : cfg.size_scale;
   end

   // threshold writes go straight to the table
   assign wr_en   = acc && (req_tuser[0] == mls_pkg::REQ_WRITE) &&
                    ({5'd0, f_lvl} < MAX_LODS8);
   assign wr_addr = AW'(row_lut[f_mesh]) * AW'(MAX_LODS) + AW'(f_lvl);

   // one table read per level
   assign rd_en   = (state_ff == ST_SCAN) && iss_act_ff;
   assign rd_addr = AW'(row_ff) * AW'(MAX_LODS) + AW'(iss_lvl_ff);

   mls_thresh_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (mls_pkg::THR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (f_thr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   // running minimum and hysteresis-scaled threshold
   always_comb begin
      nz     = (rd_q != 16'd0);
      tmin   = (rd_q < run_ff) ? rd_q : run_ff;
      h_eff  = (cfg.hysteresis > mls_pkg::HYST_MAX) ? mls_pkg::HYST_MAX : cfg.hysteresis;
      if (8'(t1_lvl_ff) <= {5'd0, prev_ff}) begin
         factor = 9'd256 + {1'b0, h_eff};
      end else begin
         factor = 9'd256 - {1'b0, h_eff};
      end
   end

   // scaled screen size, saturated
   always_comb begin
      shifted = prod_ff >> mls_pkg::FRAC_W;
      if ({1'b0, shifted} > SIZE_MAX) begin
         size_v = SIZE_MAX[SIZE_BITS-1:0];
      end else begin
         size_v = shifted[SIZE_BITS-1:0];
      end
      lhs = {size_v, 8'd0};
      hit = s2_nz_ff && (CW'(lhs) < CW'(s2_rhs_ff));
   end

   // bias sum and window clamp
   always_comb begin
      cur_coarse = signed'({{(8 - LVW){1'b0}}, coarse_ff});
      target = signed'({{(8 - LVW){1'b0}}, pick_ff})
             + {{3{lbias_ff[4]}}, lbias_ff}
             + {{3{vbias_ff[4]}}, vbias_ff}
             + {{3{cfg.global_bias[4]}}, cfg.global_bias};
      minl = signed'({5'd0, cfg.min_lod});
      maxl = {{4{cfg.max_lod[3]}}, cfg.max_lod};
      lo_s = (minl > cur_coarse) ? cur_coarse : minl;
      if (maxl < 8'sd0) begin
         hi_s = cur_coarse;
      end else if (maxl < lo_s) begin
         hi_s = lo_s;
      end else if (maxl > cur_coarse) begin
         hi_s = cur_coarse;
      end else begin
         hi_s = maxl;
      end
      if (forced_ff) begin
         res_s = signed'(fval_ff);
      end else if (target < lo_s) begin
         res_s = lo_s;
      end else if (target > hi_s) begin
         res_s = hi_s;
      end else begin
         res_s = target;
      end
   end

   assign out_free = !rsp_vld_ff || rsp_tready;

   // sequencer and pipeline next state
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      prev_in    = prev_ff;
      coarse_in  = coarse_ff;
      forced_in  = forced_ff;
      fval_in    = fval_ff;
      lbias_in   = lbias_ff;
      vbias_in   = vbias_ff;
      prod_in    = prod_ff;
      iss_act_in = iss_act_ff;
      iss_lvl_in = iss_lvl_ff;
      run_in     = run_ff;
      pick_in    = pick_ff;
      rsp_lod_in = rsp_lod_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;

      // tags follow the read through t1, then the product through s2
      t1_vld_in  = rd_en;
      t1_last_in = (iss_lvl_ff == coarse_ff);
      t1_lvl_in  = iss_lvl_ff;
      s2_vld_in  = t1_vld_ff;
      s2_nz_in   = t1_vld_ff && nz;
      s2_last_in = t1_last_ff;
      s2_lvl_in  = t1_lvl_ff;
      s2_rhs_in  = {9'd0, tmin} * {16'd0, factor};

      if (t1_vld_ff && nz) begin
         run_in = tmin;
      end

      case (state_ff)
         ST_IDLE: begin
            if (acc_sel) begin
               row_in     = row_lut[f_mesh];
               prev_in    = f_prev;
               coarse_in  = coarse8[LVW-1:0];
               forced_in  = !cfg.force_lod[3] || (f_forced != 4'd0);
               fval_in    = force8;
               lbias_in   = f_lbias;
               vbias_in   = f_vbias;
               prod_in    = {16'd0, f_size} * {16'd0, scale_eff};
               run_in     = '1;
               pick_in    = '0;
               iss_lvl_in = LVW'(1);
               iss_act_in = 1'b1;
               if (forced_in || (coarse8 == 8'd0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               if (iss_lvl_ff == coarse_ff) begin
                  iss_act_in = 1'b0;
               end else begin
                  iss_lvl_in = iss_lvl_ff + LVW'(1);
               end
            end
            if (s2_vld_ff) begin
               if (hit) begin
                  pick_in = s2_lvl_ff;
               end
               if (s2_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_lod_in = res_s[2:0];
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         iss_act_ff <= 1'b0;
         t1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         iss_act_ff <= iss_act_in;
         t1_vld_ff  <= t1_vld_in;
         s2_vld_ff  <= s2_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      prev_ff    <= prev_in;
      coarse_ff  <= coarse_in;
      forced_ff  <= forced_in;
      fval_ff    <= fval_in;
      lbias_ff   <= lbias_in;
      vbias_ff   <= vbias_in;
      prod_ff    <= prod_in;
      iss_lvl_ff <= iss_lvl_in;
      t1_last_ff <= t1_last_in;
      t1_lvl_ff  <= t1_lvl_in;
      run_ff     <= run_in;
      s2_nz_ff   <= s2_nz_in;
      s2_last_ff <= s2_last_in;
      s2_lvl_ff  <= s2_lvl_in;
      s2_rhs_ff  <= s2_rhs_in;
      pick_ff    <= pick_in;
      rsp_lod_ff <= rsp_lod_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_lod_ff};

endmodule
